// ===== rtl/core/mmsg_pkg.sv =====
`timescale 1ns / 1ps

package mmsg_pkg;

  localparam int NUM_OUTPUTS = 2;
  localparam int NUM_INPUTS = 4;
  localparam int OUT_ID_BASE = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int TOTAL_WORDS = NUM_OUTPUTS + NUM_INPUTS;
  localparam int OUT_IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int IN_IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int CNT_W = $clog2(TOTAL_WORDS);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    CMD_STATE      = 4'd0,
    CMD_CONNECT    = 4'd1,
    CMD_DISCONNECT = 4'd2,
    CMD_MUTE       = 4'd3,
    CMD_UNMUTE     = 4'd4,
    CMD_SOLO       = 4'd5,
    CMD_UNSOLO     = 4'd6,
    CMD_VOLUME     = 4'd7,
    CMD_PAN        = 4'd8,
    CMD_GAIN       = 4'd9
  } cmd_e;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_e;

  // Classified command as it travels from the front end to the back end.
  typedef struct packed {
    logic                 single;
    status_e              status;
    cmd_e                 cmd;
    logic                 self;
    logic [OUT_IDX_W-1:0] o;
    logic [IN_IDX_W-1:0]  i;
    logic [15:0]          value;
  } op_t;

  typedef struct packed {
    logic        word_valid;
    logic [7:0]  dest_out;
    logic [7:0]  dest_in;
    logic [15:0] gain;
    status_e     status;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/mmsg_cmd_if.sv =====
`timescale 1ns / 1ps

interface mmsg_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cmd;
  logic [7:0]  in_id;
  logic [7:0]  out_id;
  logic [15:0] value;

  modport source (output valid, cmd, in_id, out_id, value, input ready);
  modport sink (input valid, cmd, in_id, out_id, value, output ready);
endinterface

// ===== rtl/core/mmsg_res_if.sv =====
`timescale 1ns / 1ps

interface mmsg_res_if;
  logic        valid;
  logic        ready;
  logic        word_valid;
  logic [7:0]  dest_out;
  logic [7:0]  dest_in;
  logic [15:0] gain;
  logic        status;
  logic        last;

  modport source (output valid, word_valid, dest_out, dest_in, gain, status, last,
                  input ready);
  modport sink (input valid, word_valid, dest_out, dest_in, gain, status, last,
                output ready);
endinterface

// ===== rtl/core/mmsg_front.sv =====
`timescale 1ns / 1ps

module mmsg_front (
  mmsg_cmd_if.sink     cmd_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output mmsg_pkg::op_t push_op_o
);
  import mmsg_pkg::*;

  logic out_ok;
  logic in_ok;
  logic self;
  logic [7:0] out_off;

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;

  always_comb begin
    out_off = cmd_i.out_id - 8'(OUT_ID_BASE);
    out_ok  = (cmd_i.out_id >= 8'(OUT_ID_BASE)) &&
              (cmd_i.out_id < 8'(OUT_ID_BASE + NUM_OUTPUTS));
    self    = (cmd_i.in_id == cmd_i.out_id);
    in_ok   = self || (cmd_i.in_id < 8'(NUM_INPUTS));

    push_op_o.single = 1'b1;
    push_op_o.status = STATUS_ERR;
    push_op_o.cmd    = cmd_e'(cmd_i.cmd[3:0]);
    push_op_o.self   = self;
    push_op_o.o      = OUT_IDX_W'(out_off);
    push_op_o.i      = IN_IDX_W'(cmd_i.in_id);
    push_op_o.value  = cmd_i.value;

    // Order of checks: state query, bad code, bad ids, then the command itself.
    if (cmd_i.cmd == 8'(CMD_STATE)) begin
      push_op_o.status = STATUS_OK;
    end else if (cmd_i.cmd > 8'(CMD_GAIN)) begin
      push_op_o.status = STATUS_ERR;
    end else if (!out_ok || !in_ok) begin
      push_op_o.status = STATUS_ERR;
    end else begin
      case (cmd_e'(cmd_i.cmd[3:0]))
        CMD_CONNECT, CMD_DISCONNECT: begin
          // Connecting an output to itself makes no sense.
          if (!self) begin
            push_op_o.single = 1'b0;
            push_op_o.status = STATUS_OK;
          end
        end
        CMD_GAIN: begin
          push_op_o.status = STATUS_OK;
        end
        default: begin
          push_op_o.single = 1'b0;
          push_op_o.status = STATUS_OK;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mmsg_fifo.sv =====
`timescale 1ns / 1ps

module mmsg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mmsg_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mmsg_pkg::op_t pop_op_o
);
  import mmsg_pkg::*;

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/core/mmsg_back.sv =====
`timescale 1ns / 1ps

module mmsg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  mmsg_pkg::op_t pop_op_i,
  mmsg_res_if.source    res_o
);
  import mmsg_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [OUT_IDX_W-1:0]  o_q;
  logic                  res_valid_q;
  res_t                  res_q;

  logic [15:0]           out_vol_q [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] out_mute_q;
  logic [NUM_OUTPUTS-1:0] out_solo_q;
  logic [15:0]           in_vol_q [NUM_OUTPUTS][NUM_INPUTS];
  logic [NUM_INPUTS-1:0] in_conn_q [NUM_OUTPUTS];
  logic [NUM_INPUTS-1:0] in_mute_q [NUM_OUTPUTS];
  logic [NUM_INPUTS-1:0] in_solo_q [NUM_OUTPUTS];

  logic                  can_load;
  logic                  any_out_solo;
  logic                  any_in_solo;
  logic [OUT_IDX_W-1:0]  oi;
  logic [IN_IDX_W-1:0]   ii;
  logic                  word_last;
  res_t                  word;
  res_t                  single_word;

  // The output register can take a new word when it is empty or being drained.
  assign can_load    = !res_valid_q || res_o.ready;
  assign pop_ready_o = (state_q == ST_IDLE) && can_load;

  assign res_o.valid      = res_valid_q;
  assign res_o.word_valid = res_q.word_valid;
  assign res_o.dest_out   = res_q.dest_out;
  assign res_o.dest_in    = res_q.dest_in;
  assign res_o.gain       = res_q.gain;
  assign res_o.status     = res_q.status;
  assign res_o.last       = res_q.last;

  always_comb begin
    single_word        = '0;
    single_word.status = pop_op_i.status;
    single_word.last   = 1'b1;

    any_out_solo = |out_solo_q;
    any_in_solo  = |in_solo_q[o_q];
    oi           = OUT_IDX_W'(cnt_q);
    ii           = IN_IDX_W'(cnt_q - CNT_W'(NUM_OUTPUTS));
    word_last    = (cnt_q == CNT_W'(TOTAL_WORDS - 1));

    word.word_valid = 1'b1;
    word.status     = STATUS_OK;
    word.last       = word_last;
    word.gain       = '0;
    if (cnt_q < CNT_W'(NUM_OUTPUTS)) begin
      word.dest_out = 8'(OUT_ID_BASE) + 8'(oi);
      word.dest_in  = 8'(OUT_ID_BASE) + 8'(oi);
      if (any_out_solo) begin
        word.gain = out_solo_q[oi] ? out_vol_q[oi] : '0;
      end else begin
        word.gain = out_mute_q[oi] ? '0 : out_vol_q[oi];
      end
    end else begin
      word.dest_out = 8'(OUT_ID_BASE) + 8'(o_q);
      word.dest_in  = 8'(ii);
      if (in_conn_q[o_q][ii]) begin
        if (any_in_solo) begin
          word.gain = in_solo_q[o_q][ii] ? in_vol_q[o_q][ii] : '0;
        end else begin
          word.gain = in_mute_q[o_q][ii] ? '0 : in_vol_q[o_q][ii];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      o_q         <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      out_mute_q  <= '0;
      out_solo_q  <= '0;
      for (int n = 0; n < NUM_OUTPUTS; n++) begin
        out_vol_q[n] <= '0;
        in_conn_q[n] <= '0;
        in_mute_q[n] <= '0;
        in_solo_q[n] <= '0;
        for (int m = 0; m < NUM_INPUTS; m++) begin
          in_vol_q[n][m] <= '0;
        end
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i && can_load) begin
            if (pop_op_i.single) begin
              res_valid_q <= 1'b1;
              res_q       <= single_word;
            end else begin
              if (res_o.ready) begin
                res_valid_q <= 1'b0;
              end
              o_q     <= pop_op_i.o;
              cnt_q   <= '0;
              state_q <= ST_EMIT;
              case (pop_op_i.cmd)
                CMD_CONNECT:    in_conn_q[pop_op_i.o][pop_op_i.i] <= 1'b1;
                CMD_DISCONNECT: in_conn_q[pop_op_i.o][pop_op_i.i] <= 1'b0;
                CMD_MUTE, CMD_UNMUTE: begin
                  if (pop_op_i.self) begin
                    out_mute_q[pop_op_i.o] <= (pop_op_i.cmd == CMD_MUTE);
                  end else begin
                    in_mute_q[pop_op_i.o][pop_op_i.i] <= (pop_op_i.cmd == CMD_MUTE);
                  end
                end
                CMD_SOLO, CMD_UNSOLO: begin
                  if (pop_op_i.self) begin
                    out_solo_q[pop_op_i.o] <= (pop_op_i.cmd == CMD_SOLO);
                  end else begin
                    in_solo_q[pop_op_i.o][pop_op_i.i] <= (pop_op_i.cmd == CMD_SOLO);
                  end
                end
                CMD_VOLUME: begin
                  if (pop_op_i.self) begin
                    out_vol_q[pop_op_i.o] <= pop_op_i.value;
                  end else begin
                    in_vol_q[pop_op_i.o][pop_op_i.i] <= pop_op_i.value;
                  end
                end
                // Pan stores nothing but still re-sends the gain words.
                default: ;
              endcase
            end
          end else if (res_o.ready) begin
            res_valid_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (can_load) begin
            res_valid_q <= 1'b1;
            res_q       <= word;
            cnt_q       <= cnt_q + 1'b1;
            if (word_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.word_valid |-> res_q.status == STATUS_OK)
    else $error("gain word carries an error status");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q < CNT_W'(TOTAL_WORDS))
    else $error("word counter beyond word count");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && can_load && word_last |=> state_q == ST_IDLE && res_q.last)
    else $error("final word did not end the command");

endmodule

// ===== rtl/core/mixer_mute_solo_gain_control_core.sv =====
// Flow: an accepted command is written into the queue, and the back end takes it from the queue
// when it is idle and its output register can take a word. A single-result command's word is then
// loaded into the output register; a state-changing command first updates the tables.
// A state-changing command then sends one gain word per output and per input, one per cycle while
// the output register can take a word, so res_o.ready can stall it.
// Reset: rst_ni clears all routing tables to zero and empties the queue and output register.
`timescale 1ns / 1ps

module mixer_mute_solo_gain_control_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmsg_cmd_if.sink   cmd_i,
  mmsg_res_if.source res_o
);
  import mmsg_pkg::*;

  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  mmsg_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  mmsg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  mmsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .res_o       (res_o)
  );

endmodule
